// ===== src/rmwms_pkg.sv =====
// Shared constants and types for the range-over-mean weighted matrix sum block.
package rmwms_pkg;

   localparam int DIM      = 32;
   localparam int CELLS    = DIM * DIM;
   localparam int IDX_W    = $clog2(CELLS);
   localparam int CNT_W    = IDX_W + 1;
   localparam int ELEM_W   = 16;
   localparam int SCALE_W  = 32;
   localparam int TOT_W    = 48;
   localparam int SUM_W    = ELEM_W + IDX_W;
   localparam int NUM_W    = ELEM_W + IDX_W + 16;
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);

   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_READ  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic {
      KIND_REPORT = 1'b0,
      KIND_READ   = 1'b1
   } kind_type;

   localparam logic signed [ELEM_W-1:0] MAX_RESET = 16'sh8000;
   localparam logic signed [ELEM_W-1:0] MIN_RESET = 16'sh7FFF;

endpackage

// ===== src/rmwms_req_if.sv =====
// Request and response channel interfaces.
interface rmwms_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [1:0]                            mode;
   logic signed [rmwms_pkg::ELEM_W-1:0]   element_value;
   logic [9:0]                            read_index;
   modport source (output valid, mode, element_value, read_index, input ready);
   modport sink   (input valid, mode, element_value, read_index, output ready);
endinterface

interface rmwms_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  result_kind;
   logic signed [rmwms_pkg::SCALE_W-1:0]  scale_factor;
   logic                                  zero_average;
   logic signed [rmwms_pkg::TOT_W-1:0]    total_entry;
   logic                                  saturated;
   modport source (output valid, result_kind, scale_factor, zero_average, total_entry,
                   saturated, input ready);
   modport sink   (input valid, result_kind, scale_factor, zero_average, total_entry,
                   saturated, output ready);
endinterface

// ===== src/rmwms_ram.sv =====
// Generic simple dual-port RAM with registered read.
module rmwms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

// ===== src/range_over_mean_weighted_matrix_sum_core.sv =====
// Top level: range-over-mean weighted matrix sum engine.
//
// req_chan (sink) carries one command per beat: mode 0 loads the next Q8.8 element
// of a DIM x DIM matrix (row-major), mode 1 reads one Q24.24 total entry, mode 2
// clears the total store, mode 3 is ignored. rsp_chan (source) returns report and
// read beats through a single output register.
// Loads are accepted back to back while idle. The last element of a matrix starts a bit-serial
// divider (capture, NUM_W = 42 restoring steps, sign and saturation; capture only
// when the sum is zero) that forms scale = range * DIM^2 / sum in Q16.16,
// then a pipelined accumulate pass over both memories, one entry per cycle,
// after which the report beat is offered.
// A read first reads the total store, then the beat is registered once the output register is free.
// Clear sweeps the total store one entry per cycle; reset starts the same sweep,
// and no request is taken until it is done.
// When the receiver stalls, a finished beat holds in the output register; loads
// are still accepted, and a command needing the output waits until it frees.
module range_over_mean_weighted_matrix_sum_core (
   input  logic        clock,
   input  logic        reset,
   rmwms_req_if.sink   req_chan,
   rmwms_rsp_if.source rsp_chan
);
   localparam int EW = rmwms_pkg::ELEM_W;
   localparam int TW = rmwms_pkg::TOT_W;
   localparam int SW = rmwms_pkg::SCALE_W;
   localparam int IW = rmwms_pkg::IDX_W;
   localparam int CW = rmwms_pkg::CNT_W;
   localparam int UW = rmwms_pkg::SUM_W;
   localparam int NW = rmwms_pkg::NUM_W;
   localparam int DW = rmwms_pkg::DIV_CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLEAR, ST_DIV, ST_PASS, ST_REPORT, ST_READ
   } state_type;

   state_type state_ff, state_in;

   // running matrix statistics
   logic signed [EW-1:0] max_ff, max_in, min_ff, min_in;
   logic signed [UW-1:0] sum_ff, sum_in;
   logic [IW-1:0]        elem_cnt_ff, elem_cnt_in;

   // divider
   logic [NW-1:0]        num_ff, num_in;
   logic [UW-1:0]        mag_ff, mag_in, rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [DW-1:0]        div_cnt_ff, div_cnt_in;
   logic signed [SW-1:0] scale_ff, scale_in;
   logic                 zavg_ff, zavg_in, any_sat_ff, any_sat_in;

   // accumulate pipeline and clear sweep
   logic [CW-1:0]        iss_cnt_ff, iss_cnt_in, clr_cnt_ff, clr_cnt_in;
   logic                 rd_vld_ff, rd_vld_in, p_vld_ff, p_vld_in;
   logic [IW-1:0]        rd_addr_ff, rd_addr_in, p_addr_ff, p_addr_in;
   logic signed [TW-1:0] prod_ff, prod_in, tot_ff, tot_in;
   logic                 mark_ff, mark_in;

   // output register
   logic                 ov_ff, ov_in, okind_ff, okind_in, ozavg_ff, ozavg_in;
   logic                 osat_ff, osat_in;
   logic signed [SW-1:0] oscale_ff, oscale_in;
   logic signed [TW-1:0] otot_ff, otot_in;
   logic                 rd_inrange_ff, rd_inrange_in;

   // memories
   logic                 buf_we, buf_re, tot_we, tot_re;
   logic [IW-1:0]        buf_waddr, tot_waddr, tot_raddr;
   logic [EW-1:0]        buf_rdata;
   logic [TW:0]          tot_wdata, tot_rdata;

   // combinational helpers
   logic                 accept, out_free;
   logic signed [EW-1:0] v;
   logic signed [EW:0]   range_s;
   logic [UW:0]          rem_sh;
   logic [NW-1:0]        q;
   logic signed [TW:0]   acc;
   logic [UW-1:0]        smag;

   rmwms_ram #(.WIDTH(EW), .DEPTH(rmwms_pkg::CELLS)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(buf_waddr), .wr_data(v),
      .rd_en(buf_re), .rd_addr(iss_cnt_ff[IW-1:0]), .rd_data(buf_rdata)
   );

   // total entry with its sticky overflow mark in the top bit
   rmwms_ram #(.WIDTH(TW + 1), .DEPTH(rmwms_pkg::CELLS)) u_tot (
      .clock(clock), .wr_en(tot_we), .wr_addr(tot_waddr), .wr_data(tot_wdata),
      .rd_en(tot_re), .rd_addr(tot_raddr), .rd_data(tot_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !ov_ff || rsp_chan.ready;
   assign v              = req_chan.element_value;

   assign rsp_chan.valid        = ov_ff;
   assign rsp_chan.result_kind  = okind_ff;
   assign rsp_chan.scale_factor = oscale_ff;
   assign rsp_chan.zero_average = ozavg_ff;
   assign rsp_chan.total_entry  = otot_ff;
   assign rsp_chan.saturated    = osat_ff;

   always_comb begin
      state_in      = state_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      sum_in        = sum_ff;
      elem_cnt_in   = elem_cnt_ff;
      num_in        = num_ff;
      mag_in        = mag_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      div_cnt_in    = div_cnt_ff;
      scale_in      = scale_ff;
      zavg_in       = zavg_ff;
      any_sat_in    = any_sat_ff;
      iss_cnt_in    = iss_cnt_ff;
      clr_cnt_in    = clr_cnt_ff;
      rd_vld_in     = 1'b0;
      p_vld_in      = 1'b0;
      rd_addr_in    = iss_cnt_ff[IW-1:0];
      p_addr_in     = rd_addr_ff;
      prod_in       = TW'($signed(buf_rdata) * scale_ff);
      tot_in        = tot_rdata[TW-1:0];
      mark_in       = tot_rdata[TW];
      ov_in         = ov_ff && !rsp_chan.ready;
      okind_in      = okind_ff;
      ozavg_in      = ozavg_ff;
      osat_in       = osat_ff;
      oscale_in     = oscale_ff;
      otot_in       = otot_ff;
      rd_inrange_in = rd_inrange_ff;

      buf_we    = 1'b0;
      buf_waddr = elem_cnt_ff;
      buf_re    = 1'b0;
      tot_we    = 1'b0;
      tot_waddr = p_addr_ff;
      tot_wdata = '0;
      tot_re    = 1'b0;
      tot_raddr = iss_cnt_ff[IW-1:0];

      range_s = {max_ff[EW-1], max_ff} - {min_ff[EW-1], min_ff};
      smag    = sum_ff[UW-1] ? UW'(-sum_ff) : UW'(sum_ff);
      rem_sh  = {rem_ff, num_ff[NW-1]};
      q       = num_ff;
      acc     = {tot_ff[TW-1], tot_ff} + {prod_ff[TW-1], prod_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.mode)
                  rmwms_pkg::MODE_LOAD: begin
                     buf_we      = 1'b1;
                     if (v > max_ff) max_in = v;
                     if (v < min_ff) min_in = v;
                     sum_in      = sum_ff + UW'(v);
                     elem_cnt_in = elem_cnt_ff + 1'b1;
                     if (elem_cnt_ff == IW'(rmwms_pkg::CELLS - 1)) begin
                        state_in = ST_DIV;
                     end
                  end
                  rmwms_pkg::MODE_READ: begin
                     tot_re        = 1'b1;
                     tot_raddr     = req_chan.read_index[IW-1:0];
                     rd_inrange_in = ({1'b0, req_chan.read_index} <
                                      11'(rmwms_pkg::CELLS));
                     state_in      = ST_READ;
                  end
                  rmwms_pkg::MODE_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_CLEAR: begin
            tot_we     = 1'b1;
            tot_waddr  = clr_cnt_ff[IW-1:0];
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == CW'(rmwms_pkg::CELLS - 1)) state_in = ST_IDLE;
         end
         ST_DIV: begin
            if (div_cnt_ff == '0) begin
               // capture the finished matrix, then restart the statistics
               num_in     = NW'(range_s[EW] ? '0 : range_s[EW-1:0]) << (IW + 16);
               mag_in     = smag;
               neg_in     = sum_ff[UW-1];
               rem_in     = '0;
               zavg_in    = (sum_ff == '0);
               max_in     = rmwms_pkg::MAX_RESET;
               min_in     = rmwms_pkg::MIN_RESET;
               sum_in     = '0;
               div_cnt_in = 1'b1;
               if (sum_ff == '0) begin
                  scale_in   = '0;
                  any_sat_in = 1'b0;
                  div_cnt_in = '0;
                  iss_cnt_in = '0;
                  state_in   = ST_PASS;
               end
            end else if (div_cnt_ff <= DW'(NW)) begin
               // one restoring division step
               if (rem_sh >= {1'b0, mag_ff}) begin
                  rem_in = UW'(rem_sh - {1'b0, mag_ff});
                  num_in = {num_ff[NW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh[UW-1:0];
                  num_in = {num_ff[NW-2:0], 1'b0};
               end
               div_cnt_in = div_cnt_ff + 1'b1;
            end else begin
               if (!neg_ff) begin
                  any_sat_in = |q[NW-1:SW-1];
                  scale_in   = any_sat_in ? {1'b0, {(SW-1){1'b1}}} : SW'(q);
               end else begin
                  any_sat_in = (|q[NW-1:SW]) || (q[SW-1] && (|q[SW-2:0]));
                  scale_in   = any_sat_in ? {1'b1, {(SW-1){1'b0}}} : SW'(-q);
               end
               div_cnt_in = '0;
               iss_cnt_in = '0;
               state_in   = ST_PASS;
            end
         end
         ST_PASS: begin
            if (iss_cnt_ff < CW'(rmwms_pkg::CELLS)) begin
               buf_re     = 1'b1;
               tot_re     = 1'b1;
               rd_vld_in  = 1'b1;
               iss_cnt_in = iss_cnt_ff + 1'b1;
            end
            p_vld_in = rd_vld_ff;
            if (p_vld_ff) begin
               tot_we = 1'b1;
               if (acc[TW] != acc[TW-1]) begin
                  tot_wdata  = {1'b1, acc[TW], {(TW-1){~acc[TW]}}};
                  any_sat_in = 1'b1;
               end else begin
                  tot_wdata = {mark_ff, acc[TW-1:0]};
               end
            end
            if (!(iss_cnt_ff < CW'(rmwms_pkg::CELLS)) && !rd_vld_ff && !p_vld_ff) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               ov_in     = 1'b1;
               okind_in  = rmwms_pkg::KIND_REPORT;
               oscale_in = scale_ff;
               ozavg_in  = zavg_ff;
               otot_in   = '0;
               osat_in   = any_sat_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               ov_in     = 1'b1;
               okind_in  = rmwms_pkg::KIND_READ;
               oscale_in = '0;
               ozavg_in  = 1'b0;
               otot_in   = rd_inrange_ff ? tot_rdata[TW-1:0] : '0;
               osat_in   = rd_inrange_ff && tot_rdata[TW];
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_cnt_ff  <= '0;
         max_ff      <= rmwms_pkg::MAX_RESET;
         min_ff      <= rmwms_pkg::MIN_RESET;
         sum_ff      <= '0;
         elem_cnt_ff <= '0;
         div_cnt_ff  <= '0;
         iss_cnt_ff  <= '0;
         rd_vld_ff   <= 1'b0;
         p_vld_ff    <= 1'b0;
         ov_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         max_ff      <= max_in;
         min_ff      <= min_in;
         sum_ff      <= sum_in;
         elem_cnt_ff <= elem_cnt_in;
         div_cnt_ff  <= div_cnt_in;
         iss_cnt_ff  <= iss_cnt_in;
         rd_vld_ff   <= rd_vld_in;
         p_vld_ff    <= p_vld_in;
         ov_ff       <= ov_in;
      end
      num_ff        <= num_in;
      mag_ff        <= mag_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      scale_ff      <= scale_in;
      zavg_ff       <= zavg_in;
      any_sat_ff    <= any_sat_in;
      rd_addr_ff    <= rd_addr_in;
      p_addr_ff     <= p_addr_in;
      prod_ff       <= prod_in;
      tot_ff        <= tot_in;
      mark_ff       <= mark_in;
      okind_ff      <= okind_in;
      ozavg_ff      <= ozavg_in;
      osat_ff       <= osat_in;
      oscale_ff     <= oscale_in;
      otot_ff       <= otot_in;
      rd_inrange_ff <= rd_inrange_in;
   end
endmodule
